// ----- rtl/core/tlwheel_pkg.sv -----
package tlwheel_pkg;

	// field widths of the word on each channel
	localparam int OP_W     = 2;
	localparam int ID_W     = 16;
	localparam int PERIOD_W = 20;
	localparam int HANDLE_W = 5;
	localparam int KIND_W   = 2;

	// timer table size follows the handle field width
	localparam int TIMER_ENTRIES = 32;

	// slot list link: valid flag above the entry index
	localparam int LINK_W = HANDLE_W + 1;

	// defaults for the top level parameters
	localparam int SLOT_MS_DEF      = 10;
	localparam int FINE_SLOTS_DEF   = 256;
	localparam int COARSE_SLOTS_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED   = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_EXPIRED = 2'd2
	} kind_t;

endpackage

// ----- rtl/core/two_level_timer_wheel_top.sv -----
// Channel  | handshake           | word fields
// ---------+---------------------+------------------------------------------------
// input    | in_valid / in_ready | operation, timer_id, period_ms, periodic, handle
// output   | out_valid/out_ready | kind, handle_res, timer_id_res, last
//
// Steps: remove completes in the idle state; add runs reciprocal multiply, remainder,
// slot read, link update and result after acceptance. Tick walks the fine slot, dropping
// deleted timers, emitting expired ones and re-filing each re-armed timer through the
// same steps; on a wheel wrap a coarse slot is walked first and each timer cascades.
// Reset and clear: both head memories are swept, with in_ready low. The single
// shared multiplier and the one-port slot memories serve one step at a time. A stalled
// output holds the walk once a second expiry is waiting behind the one in the output
// register.
module two_level_timer_wheel_top
	import tlwheel_pkg::*;
#(
	parameter int SLOT_MS      = SLOT_MS_DEF,
	parameter int FINE_SLOTS   = FINE_SLOTS_DEF,
	parameter int COARSE_SLOTS = COARSE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [ID_W-1:0]     timer_id,
	input  logic [PERIOD_W-1:0] period_ms,
	input  logic                periodic,
	input  logic [HANDLE_W-1:0] handle,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [KIND_W-1:0]   kind,
	output logic [HANDLE_W-1:0] handle_res,
	output logic [ID_W-1:0]     timer_id_res,
	output logic                last
);

	localparam int FINE_SPAN = SLOT_MS * FINE_SLOTS;
	localparam int FIW  = $clog2(FINE_SLOTS);        // fine slot index
	localparam int FPW  = $clog2(FINE_SLOTS + 1);    // fine position, may equal FINE_SLOTS
	localparam int CIW  = $clog2(COARSE_SLOTS);
	localparam int CPW  = $clog2(COARSE_SLOTS + 1);
	localparam int SPW  = $clog2(FINE_SPAN);
	localparam int REMW = (SPW > PERIOD_W) ? PERIOD_W : SPW;
	localparam int SWEEP = (FINE_SLOTS > COARSE_SLOTS) ? FINE_SLOTS : COARSE_SLOTS;
	localparam int SWW  = $clog2(SWEEP + 1);

	// reciprocal constants: ceil(2^sh / d) gives an exact quotient for any delay
	localparam int SPANW   = $clog2(FINE_SPAN + 1);
	localparam int MBW     = (SPANW > PERIOD_W + 1) ? SPANW : PERIOD_W + 1;
	localparam int PRW     = PERIOD_W + MBW;
	localparam int SH_SLOT = PERIOD_W + $clog2(SLOT_MS);
	localparam int SH_SPAN = PERIOD_W + $clog2(FINE_SPAN);
	localparam longint RCP_SLOT = ((longint'(1) << SH_SLOT) + longint'(SLOT_MS) - 1)
		/ longint'(SLOT_MS);
	localparam longint RCP_SPAN = ((longint'(1) << SH_SPAN) + longint'(FINE_SPAN) - 1)
		/ longint'(FINE_SPAN);

	typedef enum logic [12:0] {
		S_SWEEP  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_ADDRES = 13'b0000000000100,
		S_CLOAD  = 13'b0000000001000,
		S_CLINK  = 13'b0000000010000,
		S_CWALK  = 13'b0000000100000,
		S_TLOAD  = 13'b0000001000000,
		S_TLINK  = 13'b0000010000000,
		S_TWALK  = 13'b0000100000000,
		S_DIV    = 13'b0001000000000,
		S_SLOT   = 13'b0010000000000,
		S_FRD    = 13'b0100000000000,
		S_FWR    = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		RET_ADD  = 2'd0,
		RET_CASC = 2'd1,
		RET_TICK = 2'd2
	} ret_t;

	state_t state_q;
	ret_t   ret_q;

	// timer table
	logic                used_q   [TIMER_ENTRIES];
	logic                del_q    [TIMER_ENTRIES];
	logic [ID_W-1:0]     id_q     [TIMER_ENTRIES];
	logic [PERIOD_W-1:0] period_q [TIMER_ENTRIES];
	logic                rep_q    [TIMER_ENTRIES];
	logic [REMW-1:0]     remn_q   [TIMER_ENTRIES];
	logic [LINK_W-1:0]   next_q   [TIMER_ENTRIES];

	// slot list memories
	logic [LINK_W-1:0]   fh_mem [FINE_SLOTS];
	logic [HANDLE_W-1:0] ft_mem [FINE_SLOTS];
	logic [LINK_W-1:0]   ch_mem [COARSE_SLOTS];
	logic [HANDLE_W-1:0] ct_mem [COARSE_SLOTS];
	logic [LINK_W-1:0]   fh_rd_q, ch_rd_q;
	logic [HANDLE_W-1:0] ft_rd_q, ct_rd_q;

	logic [FPW-1:0]      fpos_q;
	logic [CPW-1:0]      cpos_q;
	logic [SWW-1:0]      sweep_q;
	logic [LINK_W-1:0]   link_q;
	logic [HANDLE_W-1:0] e_q;
	logic                full_q;

	// shared multiplier: quotient by reciprocal, then remainder by back-multiply
	logic [PERIOD_W-1:0] dv_x_q, dv_quo_q, dv_quo, dv_rem;
	logic [PERIOD_W-1:0] mul_a;
	logic [MBW-1:0]      mul_b;
	logic [PRW-1:0]      mul_p;
	logic                coarse_q;

	logic [FIW-1:0]      fslot_q;
	logic [CIW-1:0]      cslot_q;

	// expiry held back until the next one (or the end) decides last
	logic                pend_v_q;
	logic [HANDLE_W-1:0] pend_e_q;
	logic [ID_W-1:0]     pend_id_q;

	logic                out_valid_q, last_q;
	logic [KIND_W-1:0]   kind_q;
	logic [HANDLE_W-1:0] hres_q;
	logic [ID_W-1:0]     idres_q;
	logic                out_free;
	logic                out_load;

	logic                free_any;
	logic [HANDLE_W-1:0] free_idx;

	// slot arithmetic
	logic [FIW-1:0]      f_step;
	logic [FIW+1:0]      f_sum;
	logic [CIW-1:0]      c_step;
	logic [CIW+1:0]      c_sum;

	// memory port controls
	logic [FIW-1:0]      f_addr;
	logic                fh_we, ft_we;
	logic [LINK_W-1:0]   fh_wd;
	logic [CIW-1:0]      c_addr;
	logic                ch_we, ct_we;
	logic [LINK_W-1:0]   ch_wd;

	logic [HANDLE_W-1:0] walk_e;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign handle_res   = hres_q;
	assign timer_id_res = idres_q;
	assign last      = last_q;
	assign walk_e    = link_q[HANDLE_W-1:0];

	// a word goes to the output register: add result, or the held expiry
	assign out_load = out_free && ((state_q == S_ADDRES)
		|| (state_q == S_TWALK && pend_v_q && !(link_q[LINK_W-1] && del_q[walk_e])));

	// lowest free table entry
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TIMER_ENTRIES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = HANDLE_W'(i);
			end
		end
	end

	always_comb begin
		mul_a = dv_x_q;
		mul_b = coarse_q ? MBW'(RCP_SPAN) : MBW'(RCP_SLOT);
		if (state_q == S_SLOT) begin
			mul_a = dv_quo_q;
			mul_b = MBW'(FINE_SPAN);
		end
		mul_p  = PRW'(mul_a) * PRW'(mul_b);
		dv_quo = coarse_q ? PERIOD_W'(mul_p >> SH_SPAN) : PERIOD_W'(mul_p >> SH_SLOT);
		dv_rem = dv_x_q - mul_p[PERIOD_W-1:0];
	end

	// zero delay still goes one slot ahead; coarse step saturates at the last slot
	always_comb begin
		f_step = (dv_quo_q == '0) ? FIW'(1) : dv_quo_q[FIW-1:0];
		f_sum  = (FIW+2)'(fpos_q) + (FIW+2)'(f_step);
		if (f_sum >= (FIW+2)'(FINE_SLOTS))
			f_sum = f_sum - (FIW+2)'(FINE_SLOTS);
		c_step = (dv_quo_q >= PERIOD_W'(COARSE_SLOTS)) ? CIW'(COARSE_SLOTS - 1)
			: dv_quo_q[CIW-1:0];
		c_sum  = (CIW+2)'(cpos_q) + (CIW+2)'(c_step);
		if (c_sum >= (CIW+2)'(COARSE_SLOTS))
			c_sum = c_sum - (CIW+2)'(COARSE_SLOTS);
	end

	always_comb begin
		f_addr = fslot_q;
		fh_we  = 1'b0;
		ft_we  = 1'b0;
		fh_wd  = '0;
		c_addr = cslot_q;
		ch_we  = 1'b0;
		ct_we  = 1'b0;
		ch_wd  = '0;
		case (state_q)
			S_SWEEP: begin
				f_addr = sweep_q[FIW-1:0];
				c_addr = sweep_q[CIW-1:0];
				fh_we  = (sweep_q < SWW'(FINE_SLOTS));
				ch_we  = (sweep_q < SWW'(COARSE_SLOTS));
			end
			S_CLOAD: begin
				c_addr = cpos_q[CIW-1:0];
				ch_we  = 1'b1;
			end
			S_TLOAD: begin
				f_addr = fpos_q[FIW-1:0];
				fh_we  = 1'b1;
			end
			S_FWR: begin
				if (coarse_q) begin
					ct_we = 1'b1;
					ch_we = !ch_rd_q[LINK_W-1];
					ch_wd = {1'b1, e_q};
				end else begin
					ft_we = 1'b1;
					fh_we = !fh_rd_q[LINK_W-1];
					fh_wd = {1'b1, e_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		fh_rd_q <= fh_mem[f_addr];
		ft_rd_q <= ft_mem[f_addr];
		if (fh_we)
			fh_mem[f_addr] <= fh_wd;
		if (ft_we)
			ft_mem[f_addr] <= e_q;
	end

	always_ff @(posedge clk) begin
		ch_rd_q <= ch_mem[c_addr];
		ct_rd_q <= ct_mem[c_addr];
		if (ch_we)
			ch_mem[c_addr] <= ch_wd;
		if (ct_we)
			ct_mem[c_addr] <= e_q;
	end

	// table payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid && op_t'(operation) == OP_ADD && free_any) begin
					id_q[free_idx]     <= timer_id;
					period_q[free_idx] <= period_ms;
					rep_q[free_idx]    <= periodic;
				end
			end
			S_SLOT: begin
				if (coarse_q)
					remn_q[e_q] <= dv_rem[REMW-1:0];
			end
			S_FWR: begin
				next_q[e_q] <= '0;
				if (coarse_q ? ch_rd_q[LINK_W-1] : fh_rd_q[LINK_W-1])
					next_q[coarse_q ? ct_rd_q : ft_rd_q] <= {1'b1, e_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			ret_q       <= RET_ADD;
			fpos_q      <= '0;
			cpos_q      <= '0;
			sweep_q     <= '0;
			pend_v_q    <= 1'b0;
			full_q      <= 1'b0;
			for (int i = 0; i < TIMER_ENTRIES; i++) begin
				used_q[i] <= 1'b0;
				del_q[i]  <= 1'b0;
			end
		end else begin
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SWW'(SWEEP - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						case (op_t'(operation))
							OP_ADD: begin
								if (free_any) begin
									full_q           <= 1'b0;
									used_q[free_idx] <= 1'b1;
									del_q[free_idx]  <= 1'b0;
									e_q      <= free_idx;
									ret_q    <= RET_ADD;
									dv_x_q   <= period_ms;
									coarse_q <= (32'(period_ms) >= 32'(FINE_SPAN));
									state_q  <= S_DIV;
								end else begin
									full_q  <= 1'b1;
									state_q <= S_ADDRES;
								end
							end
							OP_REMOVE: begin
								if (used_q[handle])
									del_q[handle] <= 1'b1;
							end
							OP_TICK: begin
								if (fpos_q == FPW'(FINE_SLOTS)) begin
									// wheel wrap: cascade one coarse slot first
									fpos_q <= '0;
									if (cpos_q == CPW'(COARSE_SLOTS))
										cpos_q <= '0;
									state_q <= S_CLOAD;
								end else begin
									state_q <= S_TLOAD;
								end
							end
							OP_CLEAR: begin
								for (int i = 0; i < TIMER_ENTRIES; i++) begin
									used_q[i] <= 1'b0;
									del_q[i]  <= 1'b0;
								end
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADDRES: begin
					if (out_free) begin
						kind_q  <= full_q ? KIND_FULL : KIND_ADDED;
						hres_q  <= full_q ? '0 : e_q;
						idres_q <= '0;
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CLOAD: begin
					// slot detached here, position moves on
					cpos_q  <= cpos_q + 1'b1;
					state_q <= S_CLINK;
				end
				S_CLINK: begin
					link_q  <= ch_rd_q;
					state_q <= S_CWALK;
				end
				S_CWALK: begin
					if (link_q[LINK_W-1]) begin
						link_q   <= next_q[walk_e];
						e_q      <= walk_e;
						ret_q    <= RET_CASC;
						dv_x_q   <= PERIOD_W'(remn_q[walk_e]);
						coarse_q <= 1'b0;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_TLOAD;
					end
				end
				S_TLOAD: begin
					fpos_q  <= fpos_q + 1'b1;
					state_q <= S_TLINK;
				end
				S_TLINK: begin
					link_q  <= fh_rd_q;
					state_q <= S_TWALK;
				end
				S_TWALK: begin
					if (!link_q[LINK_W-1]) begin
						if (!pend_v_q) begin
							state_q <= S_IDLE;
						end else if (out_free) begin
							kind_q   <= KIND_EXPIRED;
							hres_q   <= pend_e_q;
							idres_q  <= pend_id_q;
							last_q   <= 1'b1;
							pend_v_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end else if (del_q[walk_e]) begin
						// deleted: dropped without a word
						used_q[walk_e] <= 1'b0;
						del_q[walk_e]  <= 1'b0;
						link_q <= next_q[walk_e];
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							kind_q  <= KIND_EXPIRED;
							hres_q  <= pend_e_q;
							idres_q <= pend_id_q;
							last_q  <= 1'b0;
						end
						pend_v_q  <= 1'b1;
						pend_e_q  <= walk_e;
						pend_id_q <= id_q[walk_e];
						link_q    <= next_q[walk_e];
						if (rep_q[walk_e]) begin
							e_q      <= walk_e;
							ret_q    <= RET_TICK;
							dv_x_q   <= period_q[walk_e];
							coarse_q <= (32'(period_q[walk_e]) >= 32'(FINE_SPAN));
							state_q  <= S_DIV;
						end else begin
							used_q[walk_e] <= 1'b0;
						end
					end
				end
				S_DIV: begin
					// quotient by reciprocal multiply; remainder follows in S_SLOT
					dv_quo_q <= dv_quo;
					state_q  <= S_SLOT;
				end
				S_SLOT: begin
					fslot_q <= f_sum[FIW-1:0];
					cslot_q <= c_sum[CIW-1:0];
					state_q <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					case (ret_q)
						RET_ADD:  state_q <= S_ADDRES;
						RET_CASC: state_q <= S_CWALK;
						RET_TICK: state_q <= S_TWALK;
						default:  state_q <= S_IDLE;
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// every timer on a slot list occupies its table entry
	a_walk_used: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_TWALK || state_q == S_CWALK) && link_q[LINK_W-1])
			|-> used_q[walk_e])
		else $error("slot list links a free table entry");

	// fine position never runs past the wrap point
	a_fpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		fpos_q <= FPW'(FINE_SLOTS))
		else $error("fine position out of range");

	// a word is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(kind_q) && $stable(hres_q)
			&& $stable(idres_q) && $stable(last_q)))
		else $error("output word replaced while stalled");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import tlwheel_pkg::*;

	localparam int SLOT_MS      = SLOT_MS_DEF;
	localparam int FINE_SLOTS   = FINE_SLOTS_DEF;
	localparam int COARSE_SLOTS = COARSE_SLOTS_DEF;
	localparam int FINE_SPAN    = SLOT_MS * FINE_SLOTS;
	localparam int WATCHDOG     = 200000;

	// one expected output word
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] hnd;
		logic [ID_W-1:0]     id;
		logic                last;
	} expiry_word_t;

	// Wheel predictor plus queue of expected words. Slot lists are modeled
	// as queues of entry indexes, which keeps insertion order directly.
	class wheel_scoreboard;
		int unsigned fine_pos, coarse_pos;
		int fine_list[FINE_SLOTS][$];
		int coarse_list[COARSE_SLOTS][$];
		bit used[TIMER_ENTRIES];
		bit deleted[TIMER_ENTRIES];
		logic [ID_W-1:0] ids[TIMER_ENTRIES];
		logic [PERIOD_W-1:0] periods[TIMER_ENTRIES];
		bit repeats[TIMER_ENTRIES];
		int unsigned remainders[TIMER_ENTRIES];
		expiry_word_t pending[$];
		int errors;
		int live;

		function void wipe();
			foreach (fine_list[i]) fine_list[i].delete();
			foreach (coarse_list[i]) coarse_list[i].delete();
			foreach (used[i]) begin
				used[i] = 0;
				deleted[i] = 0;
			end
		endfunction

		function void file_entry(int e, int unsigned delay);
			int unsigned step;
			if (delay < FINE_SPAN) begin
				step = delay / SLOT_MS;
				if (step == 0) step = 1;
				fine_list[(fine_pos + step) % FINE_SLOTS].push_back(e);
			end else begin
				step = delay / FINE_SPAN;
				if (step >= COARSE_SLOTS) step = COARSE_SLOTS - 1;
				remainders[e] = delay % FINE_SPAN;
				coarse_list[(coarse_pos + step) % COARSE_SLOTS].push_back(e);
			end
		endfunction

		function void push(kind_t k, int h, logic [ID_W-1:0] id);
			expiry_word_t w;
			w.kind = k;
			w.hnd = HANDLE_W'(h);
			w.id = id;
			w.last = 0;
			pending.push_back(w);
		endfunction

		// note an accepted input word
		function void note_input(op_t op, logic [ID_W-1:0] id, logic [PERIOD_W-1:0] per,
				logic rep, logic [HANDLE_W-1:0] h);
			int e, n, slot;
			int walk[$];
			n = 0;
			case (op)
				OP_ADD: begin
					for (e = 0; e < TIMER_ENTRIES; e++)
						if (!used[e]) break;
					if (e >= TIMER_ENTRIES) begin
						push(KIND_FULL, 0, '0);
					end else begin
						used[e] = 1;
						deleted[e] = 0;
						ids[e] = id;
						periods[e] = per;
						repeats[e] = rep;
						remainders[e] = 0;
						file_entry(e, 32'(per));
						push(KIND_ADDED, e, '0);
					end
					n = 1;
				end
				OP_REMOVE: begin
					if (h < TIMER_ENTRIES && used[h]) deleted[h] = 1;
				end
				OP_TICK: begin
					if (fine_pos >= FINE_SLOTS) begin
						fine_pos = 0;
						if (coarse_pos >= COARSE_SLOTS) coarse_pos = 0;
						walk = coarse_list[coarse_pos];
						coarse_list[coarse_pos].delete();
						foreach (walk[i]) file_entry(walk[i], remainders[walk[i]]);
						coarse_pos++;
					end
					slot = fine_pos;
					fine_pos++;
					// detach first: re-armed timers land in fresh lists
					walk = fine_list[slot];
					fine_list[slot].delete();
					foreach (walk[i]) begin
						e = walk[i];
						if (deleted[e]) begin
							used[e] = 0;
							deleted[e] = 0;
						end else begin
							push(KIND_EXPIRED, e, ids[e]);
							n++;
							if (repeats[e]) file_entry(e, 32'(periods[e]));
							else used[e] = 0;
						end
					end
				end
				default: wipe();
			endcase
			if (n > 0) pending[$].last = 1;
			live = 0;
			foreach (used[i]) live += used[i];
		endfunction

		// check one accepted output word
		function void check_output(logic [KIND_W-1:0] k, logic [HANDLE_W-1:0] h,
				logic [ID_W-1:0] id, logic l);
			expiry_word_t w;
			if (pending.size() == 0) begin
				report_bad("unexpected word", '0, {k, h, id, l});
				return;
			end
			w = pending.pop_front();
			if (w.kind !== k || w.hnd !== h || w.id !== id || w.last !== l)
				report_bad("mismatch", w, {k, h, id, l});
		endfunction

		function void report_bad(string what, expiry_word_t exp_w, expiry_word_t got);
			errors++;
			if (errors <= 10)
				$display("%s: exp kind=%0d hnd=%0d id=%h last=%0b got kind=%0d hnd=%0d id=%h last=%0b",
					what, exp_w.kind, exp_w.hnd, exp_w.id, exp_w.last,
					got.kind, got.hnd, got.id, got.last);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic [ID_W-1:0]     timer_id;
	logic [PERIOD_W-1:0] period_ms;
	logic                periodic;
	logic [HANDLE_W-1:0] handle;
	logic                out_valid;
	logic                out_ready;
	logic [KIND_W-1:0]   kind;
	logic [HANDLE_W-1:0] handle_res;
	logic [ID_W-1:0]     timer_id_res;
	logic                last;

	wheel_scoreboard timers = new();
	bit  quiet;        // final stretch: no idling on either side
	bit  hold_off;     // long receiver stall request
	int  idle_cycles;

	two_level_timer_wheel_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .timer_id(timer_id), .period_ms(period_ms),
		.periodic(periodic), .handle(handle),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .handle_res(handle_res), .timer_id_res(timer_id_res), .last(last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// scoreboard hooks on accepted words; sampled at the edge, before NBA updates
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			timers.note_input(op_t'(operation), timer_id, period_ms, periodic, handle);
		if (arst_n && out_valid && out_ready)
			timers.check_output(kind, handle_res, timer_id_res, last);
	end

	// watchdog: cycles with no accepted word on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL two_level_timer_wheel_top");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		bit held;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off && !held) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				held = 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// send one word; handshake is waited out before returning
	task automatic send_word(op_t op, logic [ID_W-1:0] id, logic [PERIOD_W-1:0] per,
			logic rep, logic [HANDLE_W-1:0] h);
		int n;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		timer_id  <= id;
		period_ms <= per;
		periodic  <= rep;
		handle    <= h;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// period mostly short so timers come due within a few hundred ticks
	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return PERIOD_W'($urandom_range(0, 2 * SLOT_MS));
			1: return PERIOD_W'($urandom_range(FINE_SPAN, 3 * FINE_SPAN));
			2: return PERIOD_W'($urandom());
			default: return PERIOD_W'($urandom_range(0, 400));
		endcase
	endfunction

	task automatic random_word();
		int pick;
		op_t op;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = OP_ADD;
		else if (pick < 38)
			op = OP_REMOVE;
		else if (pick < 99)
			op = OP_TICK;
		else
			op = OP_CLEAR;
		if (op == OP_ADD && timers.live < TIMER_ENTRIES)
			send_word(op, ID_W'($urandom()), pick_period(), 1'($urandom()),
				HANDLE_W'($urandom()));
		else
			send_word(op, ID_W'($urandom()), PERIOD_W'($urandom()), 1'($urandom()),
				HANDLE_W'($urandom()));
	endtask

	initial begin
		int k, wait_n;
		quiet = 0;
		hold_off = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		timer_id = '0;
		period_ms = '0;
		periodic = 1'b0;
		handle = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero period, id zero, removes, full table
		send_word(OP_ADD, 16'h0000, 20'd0, 1'b0, '0);         // zero period, id zero
		send_word(OP_ADD, 16'hFFFF, 20'd10, 1'b1, '1);        // periodic, one slot
		send_word(OP_ADD, 16'h1234, 20'hFFFFF, 1'b0, '0);     // coarse saturates
		send_word(OP_ADD, 16'h00A5, PERIOD_W'(FINE_SPAN), 1'b1, '0); // coarse step one
		send_word(OP_REMOVE, '0, '0, 1'b0, 5'd2);             // delete pending timer
		send_word(OP_REMOVE, '0, '0, 1'b0, 5'd2);             // already deleted
		send_word(OP_REMOVE, '0, '0, 1'b0, 5'd31);            // free entry
		send_word(OP_TICK, '0, '0, 1'b0, '0);
		send_word(OP_TICK, '0, '0, 1'b0, '0);                 // two expiries, periodic one re-arms
		send_word(OP_TICK, '0, '0, 1'b0, '0);
		send_word(OP_CLEAR, '0, '0, 1'b0, '0);
		for (k = 0; k < 33; k++)                              // fills table, then refuses
			send_word(OP_ADD, 16'(k + 1), 20'd20, k[0], 5'(k));
		send_word(OP_TICK, '0, '0, 1'b0, '0);
		send_word(OP_TICK, '0, '0, 1'b0, '0);                 // slot still empty, 32 expiries due at the tick below
		send_word(OP_TICK, '0, '0, 1'b0, '0);

		// long receiver stall while ticks keep flowing, to fill the block
		hold_off = 1;
		for (k = 0; k < 20; k++)
			send_word(OP_TICK, '0, '0, 1'b0, '0);

		// random part; ticks advance the fine wheel
		for (k = 0; k < 130; k++)
			random_word();
		// mostly bare ticks, a random word every sixteenth, to push the fine wheel toward a wrap and a coarse cascade
		for (k = 0; k < 150; k++) begin
			if (k % 16 == 0) random_word();
			else send_word(OP_TICK, '0, '0, 1'b0, '0);
		end
		quiet = 1;
		for (k = 0; k < 25; k++)
			random_word();
		idle_input();

		wait_n = 0;
		while (timers.pending.size() != 0 && wait_n < WATCHDOG) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (200) @(posedge clk);
		if (timers.errors == 0 && timers.pending.size() == 0)
			$display("PASS two_level_timer_wheel_top");
		else
			$display("FAIL two_level_timer_wheel_top");
		$finish;
	end

endmodule
